// ===== sv/assert_macros.svh =====
// Assertion macros shared by the chassis serial frame link RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SFL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfl_pkg.sv =====
// Shared types and constants for the chassis serial frame link.
// Used by sfl_front, sfl_fifo, sfl_back and the top level; no dependencies.
`default_nettype none

package sfl_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 250;
    localparam int FIFO_DEPTH          = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_SPEED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_SPEED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ENABLE  = 2'd2;

    localparam logic [7:0] SYNC_FIRST      = 8'h55;
    localparam logic [7:0] SYNC_SECOND     = 8'hAA;
    localparam logic [7:0] LEN_SPEED       = 8'h09;
    localparam logic [7:0] LEN_RESET       = 8'h02;
    localparam logic [7:0] TYPE_SPEED      = 8'h01;
    localparam logic [7:0] TYPE_RESET_REQ  = 8'hFF;
    localparam logic [7:0] TYPE_RESET_ACK  = 8'h05;
    localparam logic [7:0] MIN_SPEED_LEN   = 8'd5;

    localparam logic [3:0] SPEED_LAST_IDX = 4'd13;
    localparam logic [3:0] RESET_LAST_IDX = 4'd6;

    typedef enum logic [1:0] {
        CMD_SPEED,
        CMD_RESET,
        CMD_REPORT
    } cmd_kind_t;

    // One unit of work for the transmit side.
    // Speed frame: a/b are the left/right speed words. Report: wheel counts.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  seq;
        logic [15:0] a;
        logic [15:0] b;
    } cmd_t;

    typedef struct packed {
        logic signed [6:0] left_speed;
        logic signed [6:0] right_speed;
        logic              run_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/sfl_front.sv =====
// Receive-side frame parser and command classifier.
// Depends on sfl_pkg; feeds commands into sfl_fifo.
`default_nettype none

module sfl_front #(
    parameter int MAX_PAYLOAD = sfl_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         action,
    input  wire logic [7:0]   rx_byte,
    input  wire sfl_pkg::cfg_t cfg,
    input  wire logic         fifo_full,
    output logic              push,
    output sfl_pkg::cmd_t     push_data
);
    import sfl_pkg::*;

    localparam logic [7:0] LenLimit = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_SEQ,
        PH_PAY,
        PH_CHK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic [7:0]  seq_reg, seq_next;

    logic        accept;
    logic [15:0] left_word;
    logic [15:0] right_word;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;

    assign left_word  = cfg.run_enable ? {{9{cfg.left_speed[6]}}, cfg.left_speed} : 16'd0;
    assign right_word = cfg.run_enable ? {{9{cfg.right_speed[6]}}, cfg.right_speed} : 16'd0;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        type_next  = type_reg;
        left_next  = left_reg;
        right_next = right_reg;
        seq_next   = seq_reg;
        push       = 1'b0;
        push_data  = '0;

        if (accept && action)
        begin
            // tick: speed frame, parser untouched
            push           = 1'b1;
            push_data.kind = CMD_SPEED;
            push_data.seq  = seq_reg;
            push_data.a    = left_word;
            push_data.b    = right_word;
            seq_next       = seq_reg + 8'd1;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    xor_next = 8'd0;
                    if (rx_byte == SYNC_FIRST)
                    begin
                        xor_next   = rx_byte;
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    // a bad second sync byte is dropped, not retried as first sync
                    if (rx_byte == SYNC_SECOND)
                    begin
                        xor_next   = xor_reg ^ rx_byte;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte > LenLimit)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        xor_next   = xor_reg ^ rx_byte;
                        len_next   = rx_byte;
                        idx_next   = 8'd0;
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = (len_reg == 8'd0) ? PH_CHK : PH_PAY;
                end
                PH_PAY:
                begin
                    xor_next = xor_reg ^ rx_byte;
                    case (idx_reg)
                        8'd0:    type_next  = rx_byte;
                        8'd1:    left_next  = {rx_byte, left_reg[7:0]};
                        8'd2:    left_next  = {left_reg[15:8], rx_byte};
                        8'd3:    right_next = {rx_byte, right_reg[7:0]};
                        8'd4:    right_next = {right_reg[15:8], rx_byte};
                        default: ;
                    endcase
                    idx_next = idx_reg + 8'd1;
                    if (idx_next >= len_reg)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    phase_next = PH_SYNC1;
                    if (rx_byte == xor_reg && len_reg != 8'd0)
                    begin
                        if (type_reg == TYPE_SPEED && len_reg >= MIN_SPEED_LEN)
                        begin
                            push           = 1'b1;
                            push_data.kind = CMD_REPORT;
                            push_data.a    = left_reg;
                            push_data.b    = right_reg;
                        end
                        else if (type_reg == TYPE_RESET_REQ)
                        begin
                            push           = 1'b1;
                            push_data.kind = CMD_RESET;
                            push_data.seq  = seq_reg;
                            seq_next       = seq_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            len_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            type_reg  <= 8'd0;
            left_reg  <= 16'd0;
            right_reg <= 16'd0;
            seq_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
            type_reg  <= type_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfl_fifo.sv =====
// Short command queue between the parser and the transmit serializer.
// Depends on sfl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfl_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfl_pkg::cmd_t push_data,
    input  wire logic          pop,
    output sfl_pkg::cmd_t      pop_data,
    output logic               full,
    output logic               empty
);
    import sfl_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W:0] DepthCount = (PTR_W+1)'(FIFO_DEPTH);

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == DepthCount);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SFL_ASSERT(a_count_bound, clk, rst_n, count_reg <= DepthCount, "fifo count overflow")
    `SFL_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && empty), "pop from empty fifo")
    `SFL_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

`default_nettype wire

// ===== sv/sfl_back.sv =====
// Transmit serializer: expands queued commands into output transactions.
// Depends on sfl_pkg and assert_macros.svh; drains sfl_fifo.
`default_nettype none
`include "assert_macros.svh"

module sfl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fifo_empty,
    input  wire sfl_pkg::cmd_t fifo_data,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               kind,
    output logic [7:0]         tx_byte,
    output logic [15:0]        left_count,
    output logic [15:0]        right_count,
    output logic               last
);
    import sfl_pkg::*;

    cmd_t        cmd_reg, cmd_next;
    logic        active_reg, active_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  tx_reg, tx_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic        last_reg, last_next;

    logic        out_ready;
    logic        emit;
    logic        final_item;
    logic [7:0]  frame_byte;

    assign out_ready = !out_valid_reg || !out_stall;
    assign emit      = active_reg && out_ready;

    always_comb
    begin
        unique case (cmd_reg.kind)
            CMD_SPEED:  final_item = (idx_reg == SPEED_LAST_IDX);
            CMD_RESET:  final_item = (idx_reg == RESET_LAST_IDX);
            default:    final_item = 1'b1;
        endcase
    end

    // next chain back-to-back: pop as the current frame's last byte goes out
    assign pop = !fifo_empty && (!active_reg || (emit && final_item));

    always_comb
    begin
        frame_byte = 8'd0;
        if (final_item)
        begin
            frame_byte = xor_reg;
        end
        else
        begin
            unique case (idx_reg)
                4'd0:    frame_byte = SYNC_FIRST;
                4'd1:    frame_byte = SYNC_SECOND;
                4'd2:    frame_byte = (cmd_reg.kind == CMD_SPEED) ? LEN_SPEED : LEN_RESET;
                4'd3:    frame_byte = cmd_reg.seq;
                4'd4:    frame_byte = (cmd_reg.kind == CMD_SPEED) ? TYPE_SPEED : TYPE_RESET_ACK;
                4'd5:    frame_byte = (cmd_reg.kind == CMD_SPEED) ? cmd_reg.a[15:8] : 8'd0;
                4'd6:    frame_byte = cmd_reg.a[7:0];
                4'd7:    frame_byte = cmd_reg.b[15:8];
                4'd8:    frame_byte = cmd_reg.b[7:0];
                default: frame_byte = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        xor_next       = xor_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        tx_next        = tx_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = final_item;
            if (cmd_reg.kind == CMD_REPORT)
            begin
                kind_next  = 1'b1;
                tx_next    = 8'd0;
                left_next  = cmd_reg.a;
                right_next = cmd_reg.b;
            end
            else
            begin
                kind_next  = 1'b0;
                tx_next    = frame_byte;
                left_next  = 16'd0;
                right_next = 16'd0;
            end
            idx_next = idx_reg + 4'd1;
            xor_next = xor_reg ^ frame_byte;
            if (final_item)
            begin
                active_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            cmd_next    = fifo_data;
            active_next = 1'b1;
            idx_next    = 4'd0;
            xor_next    = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        xor_reg   <= xor_next;
        kind_reg  <= kind_next;
        tx_reg    <= tx_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign tx_byte     = tx_reg;
    assign left_count  = left_reg;
    assign right_count = right_reg;
    assign last        = last_reg;

    `SFL_ASSERT(a_report_single, clk, rst_n, !(out_valid_reg && kind_reg) || last_reg, "report not last")
    `SFL_ASSERT(a_idx_bound, clk, rst_n, !active_reg || idx_reg <= SPEED_LAST_IDX, "frame index overrun")

endmodule

`default_nettype wire

// ===== sv/chassis_serial_frame_link_unit.sv =====
// Top level of the chassis serial frame link: config registers, parser, queue, serializer.
// Depends on sfl_pkg, sfl_front, sfl_fifo and sfl_back.
`default_nettype none

// Each input transaction is either a received serial byte or a control tick.
// The parser works on a received byte as soon as it is taken and
// emits nothing until the checksum byte of a valid frame. A valid wheel-count
// frame yields one report transaction; a valid reset request yields a 7-byte
// reset frame; a tick yields a 14-byte speed frame. Frames go out one byte per
// cycle from the serializer while the output is not stalled; consecutive frames
// follow with no gap. A 4-entry command queue sits between parser and
// serializer, so input is stalled only when four commands are waiting. Speed
// settings are sampled when the tick is accepted.
module chassis_serial_frame_link_unit #(
    parameter int MAX_PAYLOAD = sfl_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            action,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 kind,
    output logic [7:0]                           tx_byte,
    output logic [15:0]                          left_count,
    output logic [15:0]                          right_count,
    output logic                                 last,
    input  wire logic                            cfg_we,
    input  wire logic [sfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfl_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t push_data;
    cmd_t pop_data;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_SPEED:  cfg_next.left_speed  = cfg_data;
                CFG_RIGHT_SPEED: cfg_next.right_speed = cfg_data;
                CFG_RUN_ENABLE:  cfg_next.run_enable  = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_speed  <= 7'sd0;
            cfg_reg.right_speed <= 7'sd0;
            cfg_reg.run_enable  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfl_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    sfl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    sfl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .fifo_data   (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .tx_byte     (tx_byte),
        .left_count  (left_count),
        .right_count (right_count),
        .last        (last)
    );

endmodule

`default_nettype wire
